// ----- rtl/core/fqa_pkg.sv -----
// Shared types and constants for the Q24.8 fixed-point ALU.
// Depends on nothing; every other file of the block imports it.
package fqa_pkg;

    localparam int RAW_W = 32;

    localparam logic signed [RAW_W-1:0] RAW_MAX = {1'b0, {(RAW_W-1){1'b1}}};
    localparam logic signed [RAW_W-1:0] RAW_MIN = {1'b1, {(RAW_W-1){1'b0}}};

    typedef enum logic [3:0] {
        FN_ADD      = 4'd0,
        FN_SUB      = 4'd1,
        FN_MUL      = 4'd2,
        FN_DIV      = 4'd3,
        FN_GT       = 4'd4,
        FN_LT       = 4'd5,
        FN_GE       = 4'd6,
        FN_LE       = 4'd7,
        FN_EQ       = 4'd8,
        FN_NE       = 4'd9,
        FN_MIN      = 4'd10,
        FN_MAX      = 4'd11,
        FN_INC      = 4'd12,
        FN_DEC      = 4'd13,
        FN_TO_INT   = 4'd14,
        FN_FROM_INT = 4'd15
    } t_func;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_OVF  = 2'd1,
        ERR_DIV0 = 2'd2
    } t_err;

    // Everything that rides alongside the divider chain.
    typedef struct packed {
        t_func                   func;
        logic signed [RAW_W-1:0] res;
        logic                    cmp;
        t_err                    err;
        logic                    neg;
        logic [2*RAW_W-1:0]      prod;
    } t_side;

    // Saturate a 33-bit signed sum into 32 bits; the top bit of the
    // return value is the overflow flag.
    function automatic logic [RAW_W:0] sat33(input logic signed [RAW_W:0] v);
        logic ovf;
        logic [RAW_W-1:0] r;
        ovf = v[RAW_W] != v[RAW_W-1];
        if (ovf) begin
            r = v[RAW_W] ? RAW_MIN : RAW_MAX;
        end else begin
            r = v[RAW_W-1:0];
        end
        return {ovf, r};
    endfunction

endpackage

// ----- rtl/core/fqa_in_if.sv -----
// Input channel of the fixed-point ALU: valid, ready and one operation beat.
// Depends on fqa_pkg.
interface fqa_in_if import fqa_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [3:0]              func;
    logic signed [RAW_W-1:0] operand_a;
    logic signed [RAW_W-1:0] operand_b;

    modport source (output valid, output func, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input func, input operand_a, input operand_b,
                    output ready);
endinterface

// ----- rtl/core/fqa_out_if.sv -----
// Output channel of the fixed-point ALU: valid, ready and one result beat.
// Depends on fqa_pkg.
interface fqa_out_if import fqa_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [RAW_W-1:0] result_raw;
    logic                    compare_true;
    logic [1:0]              error_code;

    modport source (output valid, output result_raw, output compare_true,
                    output error_code, input ready);
    modport sink   (input valid, input result_raw, input compare_true,
                    input error_code, output ready);
endinterface

// ----- rtl/core/fixed_point_q24_8_alu.sv -----
// Top level of the signed Q24.8 fixed-point ALU: front stages, divider chain
// and back stages. Depends on fqa_pkg, fqa_in_if, fqa_out_if and the stage modules.
//
//   Channel    Direction  Beat contents
//   i_in_chan  in         func, operand_a, operand_b
//   o_out_chan out        result_raw, compare_true, error_code
//
// One beat is accepted per cycle when the pipeline is flowing. Every
// operation passes FRACTION_BITS + 36 registers (44 at the default): two front
// stages, one divider stage per quotient bit across 32 + FRACTION_BITS stages,
// and two back stages, on its way from the input channel to the output channel.
// Reset is synchronous and active low; it clears only the valid bits.
// Each stage holds its beat while the stage after it is full and stalled,
// so a stall at the output fills empty stages first and nothing is lost.
module fixed_point_q24_8_alu import fqa_pkg::*; #(
    parameter int FRACTION_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fqa_in_if.sink      i_in_chan,
    fqa_out_if.source   o_out_chan
);

    localparam int NW = RAW_W + FRACTION_BITS;

    // Links between the stages of the divider chain; link 0 is fed by the
    // front end and link NW feeds the back end.
    logic             v    [0:NW];
    logic             rdy  [0:NW];
    t_side            side [0:NW];
    logic [NW-1:0]    num  [0:NW];
    logic [RAW_W-1:0] rem  [0:NW];
    logic [NW-1:0]    quot [0:NW];
    logic [RAW_W-1:0] den  [0:NW];
    logic [1:0]       err_out;

    fqa_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_chan.valid),
        .o_ready (i_in_chan.ready),
        .i_func  (i_in_chan.func),
        .i_a     (i_in_chan.operand_a),
        .i_b     (i_in_chan.operand_b),
        .o_valid (v[0]),
        .i_ready (rdy[0]),
        .o_side  (side[0]),
        .o_num   (num[0]),
        .o_den   (den[0])
    );

    // The partial remainder and quotient start empty.
    assign rem[0]  = '0;
    assign quot[0] = '0;

    for (genvar k = 0; k < NW; k++) begin : g_div
        fqa_div_step #(.NW(NW)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[k]),
            .o_ready (rdy[k]),
            .i_side  (side[k]),
            .i_num   (num[k]),
            .i_rem   (rem[k]),
            .i_quot  (quot[k]),
            .i_den   (den[k]),
            .o_valid (v[k+1]),
            .i_ready (rdy[k+1]),
            .o_side  (side[k+1]),
            .o_num   (num[k+1]),
            .o_rem   (rem[k+1]),
            .o_quot  (quot[k+1]),
            .o_den   (den[k+1])
        );
    end

    fqa_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (v[NW]),
        .o_ready  (rdy[NW]),
        .i_side   (side[NW]),
        .i_quot   (quot[NW]),
        .i_rem    (rem[NW]),
        .i_den    (den[NW]),
        .o_valid  (o_out_chan.valid),
        .i_ready  (o_out_chan.ready),
        .o_result (o_out_chan.result_raw),
        .o_cmp    (o_out_chan.compare_true),
        .o_err    (err_out)
    );

    assign o_out_chan.error_code = err_out;

    // A divide by zero always comes out as a zero result with the compare flag clear.
    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_chan.valid && err_out == ERR_DIV0
        |-> o_out_chan.result_raw == '0 && !o_out_chan.compare_true)
        else $error("divide by zero beat carries a non-zero result");

    // A true comparison never carries a result word or an error.
    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_chan.valid && o_out_chan.compare_true
        |-> o_out_chan.result_raw == '0 && err_out == ERR_NONE)
        else $error("comparison beat carries a result or an error");

    // The input only backs up when every stage is full and the output stalls.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_chan.ready |-> o_out_chan.valid && !o_out_chan.ready)
        else $error("input stalled while the pipeline could move");

    // The error code never takes its unused value.
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_chan.valid |-> err_out <= ERR_DIV0)
        else $error("unused error code on the output");

endmodule

// ----- rtl/core/fqa_front.sv -----
// Front two stages: decode, the simple operations, magnitudes and the product.
// Depends on fqa_pkg.
module fqa_front import fqa_pkg::*; #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [3:0]                         i_func,
    input  logic signed [RAW_W-1:0]            i_a,
    input  logic signed [RAW_W-1:0]            i_b,
    output logic                               o_valid,
    input  logic                               i_ready,
    output t_side                              o_side,
    output logic [RAW_W+FRACTION_BITS-1:0]     o_num,
    output logic [RAW_W-1:0]                   o_den
);

    localparam int F = FRACTION_BITS;

    logic                    r_va, r_vb;
    t_func                   r_func;
    logic signed [RAW_W-1:0] r_res;
    logic                    r_cmp;
    t_err                    r_err;
    logic                    r_neg;
    logic [RAW_W-1:0]        r_mag_a, r_mag_b;
    t_side                   r_side;
    logic [RAW_W-1:0]        r_num_hi;
    logic [RAW_W-1:0]        r_den;

    logic rdy_a, rdy_b;

    t_func                   n_func;
    logic signed [RAW_W-1:0] n_res;
    logic                    n_cmp;
    t_err                    n_err;

    logic signed [RAW_W:0] a33, b33, bias;
    logic [RAW_W:0]        s_add, s_sub, s_inc, s_dec;
    logic signed [RAW_W:0] trunc;
    logic [F:0]            top_bits;
    logic                  from_ovf;
    logic                  lt, gt, eq;

    assign rdy_b   = !r_vb || i_ready;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;

    always_comb begin
        n_func   = t_func'(i_func);
        a33      = {i_a[RAW_W-1], i_a};
        b33      = {i_b[RAW_W-1], i_b};
        s_add    = sat33(a33 + b33);
        s_sub    = sat33(a33 - b33);
        s_inc    = sat33(a33 + (RAW_W+1)'(1));
        s_dec    = sat33(a33 - (RAW_W+1)'(1));
        // Rounding toward zero: bias negative values before the shift.
        bias     = {{(RAW_W+1-F){1'b0}}, {F{i_a[RAW_W-1]}}};
        trunc    = (a33 + bias) >>> F;
        top_bits = i_a[RAW_W-1 -: F+1];
        from_ovf = !((&top_bits) || !(|top_bits));
        lt       = i_a < i_b;
        gt       = i_a > i_b;
        eq       = i_a == i_b;
        n_res    = '0;
        n_cmp    = 1'b0;
        n_err    = ERR_NONE;
        unique case (n_func)
            FN_ADD:      begin n_res = s_add[RAW_W-1:0]; n_err = s_add[RAW_W] ? ERR_OVF : ERR_NONE; end
            FN_SUB:      begin n_res = s_sub[RAW_W-1:0]; n_err = s_sub[RAW_W] ? ERR_OVF : ERR_NONE; end
            FN_MUL:      n_res = '0;
            FN_DIV:      n_res = '0;
            FN_GT:       n_cmp = gt;
            FN_LT:       n_cmp = lt;
            FN_GE:       n_cmp = !lt;
            FN_LE:       n_cmp = !gt;
            FN_EQ:       n_cmp = eq;
            FN_NE:       n_cmp = !eq;
            FN_MIN:      n_res = lt ? i_a : i_b;
            FN_MAX:      n_res = gt ? i_a : i_b;
            FN_INC:      begin n_res = s_inc[RAW_W-1:0]; n_err = s_inc[RAW_W] ? ERR_OVF : ERR_NONE; end
            FN_DEC:      begin n_res = s_dec[RAW_W-1:0]; n_err = s_dec[RAW_W] ? ERR_OVF : ERR_NONE; end
            FN_TO_INT:   n_res = trunc[RAW_W-1:0];
            FN_FROM_INT: begin
                if (from_ovf) begin
                    n_res = i_a[RAW_W-1] ? RAW_MIN : RAW_MAX;
                    n_err = ERR_OVF;
                end else begin
                    n_res = {i_a[RAW_W-1-F:0], {F{1'b0}}};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_va <= i_valid;
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
        end
        if (rdy_a && i_valid) begin
            r_func  <= n_func;
            r_res   <= n_res;
            r_cmp   <= n_cmp;
            r_err   <= n_err;
            r_neg   <= i_a[RAW_W-1] ^ i_b[RAW_W-1];
            r_mag_a <= i_a[RAW_W-1] ? RAW_W'(0) - i_a : i_a;
            r_mag_b <= i_b[RAW_W-1] ? RAW_W'(0) - i_b : i_b;
        end
        if (rdy_b && r_va) begin
            r_side.func <= r_func;
            r_side.res  <= r_res;
            r_side.cmp  <= r_cmp;
            r_side.err  <= r_err;
            r_side.neg  <= r_neg;
            r_side.prod <= r_mag_a * r_mag_b;
            r_num_hi    <= r_mag_a;
            r_den       <= r_mag_b;
        end
    end

    assign o_valid = r_vb;
    assign o_side  = r_side;
    assign o_num   = {r_num_hi, {F{1'b0}}};
    assign o_den   = r_den;

endmodule

// ----- rtl/core/fqa_div_step.sv -----
// One restoring-division stage: one quotient bit per beat, side data carried.
// Depends on fqa_pkg.
module fqa_div_step import fqa_pkg::*; #(
    parameter int NW = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_side            i_side,
    input  logic [NW-1:0]    i_num,
    input  logic [RAW_W-1:0] i_rem,
    input  logic [NW-1:0]    i_quot,
    input  logic [RAW_W-1:0] i_den,
    output logic             o_valid,
    input  logic             i_ready,
    output t_side            o_side,
    output logic [NW-1:0]    o_num,
    output logic [RAW_W-1:0] o_rem,
    output logic [NW-1:0]    o_quot,
    output logic [RAW_W-1:0] o_den
);

    logic             r_v;
    t_side            r_side;
    logic [NW-1:0]    r_num, r_quot;
    logic [RAW_W-1:0] r_rem, r_den;

    logic [RAW_W:0]   trial, diff;
    logic             ge;

    assign o_ready = !r_v || i_ready;

    always_comb begin
        trial = {i_rem, i_num[NW-1]};
        diff  = trial - {1'b0, i_den};
        ge    = trial >= {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_side <= i_side;
            r_num  <= {i_num[NW-2:0], 1'b0};
            r_rem  <= ge ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
            r_quot <= {i_quot[NW-2:0], ge};
            r_den  <= i_den;
        end
    end

    assign o_valid = r_v;
    assign o_side  = r_side;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_quot  = r_quot;
    assign o_den   = r_den;

endmodule

// ----- rtl/core/fqa_back.sv -----
// Back two stages: rounding of product and quotient, then sign, saturation
// and result selection into the output register. Depends on fqa_pkg.
module fqa_back import fqa_pkg::*; #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  t_side                           i_side,
    input  logic [RAW_W+FRACTION_BITS-1:0]  i_quot,
    input  logic [RAW_W-1:0]                i_rem,
    input  logic [RAW_W-1:0]                i_den,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [RAW_W-1:0]         o_result,
    output logic                            o_cmp,
    output logic [1:0]                      o_err
);

    localparam int F = FRACTION_BITS;
    localparam int MW = 2 * RAW_W;

    logic                    r_vr, r_vz;
    t_side                   r_side;
    logic [MW-1:0]           r_mag;
    logic                    r_div0;
    logic signed [RAW_W-1:0] r_result;
    logic                    r_cmp;
    t_err                    r_err;

    logic rdy_r, rdy_z;

    logic [MW-1:0]           n_mag;
    logic                    div_up;
    logic signed [RAW_W-1:0] n_result;
    logic                    n_cmp;
    t_err                    n_err;
    logic                    ovf;
    logic [RAW_W-1:0]        signed_val;

    assign rdy_z   = !r_vz || i_ready;
    assign rdy_r   = !r_vr || rdy_z;
    assign o_ready = rdy_r;

    always_comb begin
        // Half an LSB or more of remainder rounds the magnitude up.
        div_up = {i_rem, 1'b0} >= {1'b0, i_den};
        if (i_side.func == FN_DIV) begin
            n_mag = MW'(i_quot) + MW'(div_up);
        end else begin
            n_mag = (i_side.prod + (MW'(1) << (F - 1))) >> F;
        end
    end

    always_comb begin
        signed_val = r_side.neg ? RAW_W'(0) - r_mag[RAW_W-1:0] : r_mag[RAW_W-1:0];
        if (r_side.neg) begin
            ovf = r_mag > MW'({1'b1, {(RAW_W-1){1'b0}}});
        end else begin
            ovf = r_mag > MW'(RAW_MAX);
        end
        n_result = r_side.res;
        n_cmp    = r_side.cmp;
        n_err    = r_side.err;
        if (r_side.func == FN_MUL || r_side.func == FN_DIV) begin
            n_cmp = 1'b0;
            if (r_div0) begin
                n_result = '0;
                n_err    = ERR_DIV0;
            end else if (ovf) begin
                n_result = r_side.neg ? RAW_MIN : RAW_MAX;
                n_err    = ERR_OVF;
            end else begin
                n_result = signed_val;
                n_err    = ERR_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr <= 1'b0;
            r_vz <= 1'b0;
        end else begin
            if (rdy_r) begin
                r_vr <= i_valid;
            end
            if (rdy_z) begin
                r_vz <= r_vr;
            end
        end
        if (rdy_r && i_valid) begin
            r_side <= i_side;
            r_mag  <= n_mag;
            r_div0 <= (i_side.func == FN_DIV) && (i_den == '0);
        end
        if (rdy_z && r_vr) begin
            r_result <= n_result;
            r_cmp    <= n_cmp;
            r_err    <= n_err;
        end
    end

    assign o_valid  = r_vz;
    assign o_result = r_result;
    assign o_cmp    = r_cmp;
    assign o_err    = r_err;

endmodule
